### rtl/core/hmrcm_pkg.sv
// ----------------------------------------------------------------------------
// hmrcm_pkg
// Shared types, widths and constants of the HSV multi-range color mask.
// ----------------------------------------------------------------------------
package hmrcm_pkg;

    localparam int PIX_W      = 8;
    localparam int FIX_SHIFT  = 12;
    localparam int NUM_BOXES  = 3;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_C = 2'd2;

    localparam logic [CFG_W-1:0] RANGE_A_RESET = 48'h1E2B14_7CFFB4;
    localparam logic [CFG_W-1:0] RANGE_B_RESET = 48'h0F2819_1E503C;
    localparam logic [CFG_W-1:0] RANGE_C_RESET = 48'h3C3CBE_64A0FF;

    // Restoring divider settings, common to both reciprocals.
    localparam int DIV_NUM_W      = 21;
    localparam int DIV_DEN_W      = PIX_W + 1;
    localparam int DIV_BITS_STAGE = 3;
    localparam int DIV_STAGES     = DIV_NUM_W / DIV_BITS_STAGE;

    // Numerators without the rounding term: 2*255<<12 and 2*30<<12.
    localparam int S_NUM_BASE = 2 * 255 * (1 << FIX_SHIFT);
    localparam int H_NUM_BASE = 2 * 30 * (1 << FIX_SHIFT);

    localparam int SDIV_W  = 20;
    localparam int HDIV_W  = 17;
    localparam int RAW_W   = 12;
    localparam int SPROD_W = PIX_W + SDIV_W;
    localparam int HPROD_W = 30;
    localparam int SSUM_W  = SPROD_W + 1;
    localparam int T_W     = HPROD_W + 1;
    localparam int HFULL_W = T_W - FIX_SHIFT;
    localparam int SFULL_W = SSUM_W - FIX_SHIFT;

    localparam int ROUND_HALF = 1 << (FIX_SHIFT - 1);
    localparam int H_BIAS     = ROUND_HALF + 180 * (1 << FIX_SHIFT);
    localparam int HUE_WRAP   = 180;
    localparam int PIX_MAX    = 255;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;   // numerator bits not yet consumed, MSB first
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_NUM_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic [PIX_W-1:0]        vmax;
        logic [PIX_W-1:0]        diff;
        logic signed [RAW_W-1:0] raw;
        t_div                    sdv;
        t_div                    hdv;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] sat;
        logic [PIX_W-1:0] val;
    } t_hsv;

    typedef struct packed {
        logic [PIX_W-1:0] lo_h;
        logic [PIX_W-1:0] lo_s;
        logic [PIX_W-1:0] lo_v;
        logic [PIX_W-1:0] hi_h;
        logic [PIX_W-1:0] hi_s;
        logic [PIX_W-1:0] hi_v;
    } t_box;

    // One step of restoring division: bring down one numerator bit.
    function automatic t_div div_step(input t_div d);
        logic [DIV_DEN_W:0] shifted;
        t_div               o;
        o       = d;
        shifted = {d.rem, d.num[DIV_NUM_W-1]};
        if (shifted >= {1'b0, d.den}) begin
            shifted = shifted - {1'b0, d.den};
            o.quo   = {d.quo[DIV_NUM_W-2:0], 1'b1};
        end else begin
            o.quo   = {d.quo[DIV_NUM_W-2:0], 1'b0};
        end
        o.rem = shifted[DIV_DEN_W-1:0];
        o.num = {d.num[DIV_NUM_W-2:0], 1'b0};
        return o;
    endfunction

endpackage

### rtl/core/hmrcm_front.sv
// ----------------------------------------------------------------------------
// hmrcm_front
// First stage: channel max/min, hue numerator and divider setup.
// ----------------------------------------------------------------------------
module hmrcm_front import hmrcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_red,
    output logic             o_valid,
    output t_item            o_item
);

    logic                    r_valid;
    t_item                   r_item;
    t_item                   n_item;
    logic [PIX_W-1:0]        vmax;
    logic [PIX_W-1:0]        vmin;
    logic [PIX_W-1:0]        diff;
    logic signed [RAW_W-1:0] sb, sg, sr, sd;

    always_comb begin
        vmax = i_blue;
        vmin = i_blue;
        if (i_green > vmax) vmax = i_green;
        if (i_red > vmax)   vmax = i_red;
        if (i_green < vmin) vmin = i_green;
        if (i_red < vmin)   vmin = i_red;
        diff = vmax - vmin;
    end

    assign sb = signed'({4'b0, i_blue});
    assign sg = signed'({4'b0, i_green});
    assign sr = signed'({4'b0, i_red});
    assign sd = signed'({4'b0, diff});

    always_comb begin
        n_item      = '0;
        n_item.vmax = vmax;
        n_item.diff = diff;
        // Red wins ties, then green, then blue.
        if (vmax == i_red) begin
            n_item.raw = sg - sb;
        end else if (vmax == i_green) begin
            n_item.raw = sb - sr + (sd <<< 1);
        end else begin
            n_item.raw = sr - sg + (sd <<< 2);
        end
        n_item.sdv.num = DIV_NUM_W'(S_NUM_BASE) + DIV_NUM_W'(vmax);
        n_item.sdv.den = {vmax, 1'b0};
        n_item.hdv.num = DIV_NUM_W'(H_NUM_BASE) + DIV_NUM_W'(diff);
        n_item.hdv.den = {diff, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/hmrcm_div_stage.sv
// ----------------------------------------------------------------------------
// hmrcm_div_stage
// One divider stage: DIV_BITS_STAGE quotient bits of both reciprocals per cycle while i_en is high.
// ----------------------------------------------------------------------------
module hmrcm_div_stage import hmrcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item = i_item;
        for (int k = 0; k < DIV_BITS_STAGE; k++) begin
            n_item.sdv = div_step(n_item.sdv);
            n_item.hdv = div_step(n_item.hdv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/hmrcm_arith.sv
// ----------------------------------------------------------------------------
// hmrcm_arith
// Two stages: reciprocal products, then rounding, wrap and clamping of H and S.
// ----------------------------------------------------------------------------
module hmrcm_arith import hmrcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_hsv  o_hsv
);

    logic                      r_valid_m;
    logic [SPROD_W-1:0]        r_sprod;
    logic signed [HPROD_W-1:0] r_hprod;
    logic [PIX_W-1:0]          r_vmax;
    logic [SPROD_W-1:0]        n_sprod;
    logic signed [HPROD_W-1:0] n_hprod;
    logic signed [HPROD_W-1:0] raw_x;
    logic signed [HPROD_W-1:0] hdiv_x;

    logic                      r_valid;
    t_hsv                      r_hsv;
    t_hsv                      n_hsv;
    logic [SSUM_W-1:0]         s_sum;
    logic [SFULL_W-1:0]        s_full;
    logic signed [T_W-1:0]     t_sum;
    logic [HFULL_W-1:0]        h_full;

    // Stage one: the two products.
    assign n_sprod = SPROD_W'(i_item.diff) * SPROD_W'(i_item.sdv.quo[SDIV_W-1:0]);
    assign raw_x   = HPROD_W'(i_item.raw);
    assign hdiv_x  = signed'(HPROD_W'(i_item.hdv.quo[HDIV_W-1:0]));
    assign n_hprod = raw_x * hdiv_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
        end else if (i_en) begin
            r_valid_m <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sprod <= n_sprod;
            r_hprod <= n_hprod;
            r_vmax  <= i_item.vmax;
        end
    end

    // Stage two: round to whole units and bring into range.
    always_comb begin
        s_sum  = SSUM_W'(r_sprod) + SSUM_W'(ROUND_HALF);
        s_full = s_sum[SSUM_W-1:FIX_SHIFT];
        t_sum  = T_W'(r_hprod) + T_W'(H_BIAS);
        if (t_sum < 0) begin
            h_full = '0;
        end else begin
            h_full = t_sum[T_W-1:FIX_SHIFT];
        end
        if (h_full >= HFULL_W'(HUE_WRAP)) begin
            h_full = h_full - HFULL_W'(HUE_WRAP);
        end
        n_hsv.val = r_vmax;
        n_hsv.sat = (s_full > SFULL_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : s_full[PIX_W-1:0];
        n_hsv.hue = (h_full > HFULL_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : h_full[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_valid_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hsv <= n_hsv;
        end
    end

    assign o_valid = r_valid;
    assign o_hsv   = r_hsv;

endmodule

### rtl/core/hmrcm_match.sv
// ----------------------------------------------------------------------------
// hmrcm_match
// Last stage: tests the HSV value against the boxes and holds the output item.
// ----------------------------------------------------------------------------
module hmrcm_match import hmrcm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_hsv                   i_hsv,
    input  t_box [NUM_BOXES-1:0]   i_boxes,
    output logic                   o_valid,
    output logic                   o_mask,
    output t_hsv                   o_hsv
);

    logic                 r_valid;
    logic                 r_mask;
    t_hsv                 r_hsv;
    logic                 n_mask;
    logic [NUM_BOXES-1:0] hit;

    always_comb begin
        for (int i = 0; i < NUM_BOXES; i++) begin
            hit[i] = (i_hsv.hue >= i_boxes[i].lo_h) && (i_hsv.hue <= i_boxes[i].hi_h) &&
                     (i_hsv.sat >= i_boxes[i].lo_s) && (i_hsv.sat <= i_boxes[i].hi_s) &&
                     (i_hsv.val >= i_boxes[i].lo_v) && (i_hsv.val <= i_boxes[i].hi_v);
        end
        n_mask = |hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mask <= n_mask;
            r_hsv  <= i_hsv;
        end
    end

    assign o_valid = r_valid;
    assign o_mask  = r_mask;
    assign o_hsv   = r_hsv;

endmodule

### rtl/core/hsv_multi_range_color_mask.sv
// ----------------------------------------------------------------------------
// hsv_multi_range_color_mask
// BGR pixel to 8-bit HSV conversion with a three-box color mask.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while o_stall is low and presents the
// result item of each pixel in order, through eleven register stages. The
// depth is set by the two reciprocals with 12 fraction bits (of the
// maximum for S, of the channel spread for H), which run through a
// shared-format restoring divider of seven stages, three quotient bits per
// stage; one front stage, one multiply stage, one rounding stage and one
// box-compare stage complete the pipeline. A stall on the output freezes the
// whole pipeline, so no item is lost or repeated. The boxes are read live from
// the configuration registers and should only be rewritten while idle.
module hsv_multi_range_color_mask import hmrcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_blue,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_red,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_mask_bit,
    output logic [PIX_W-1:0]     o_hue,
    output logic [PIX_W-1:0]     o_saturation,
    output logic [PIX_W-1:0]     o_brightness,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic                 en;
    logic [CFG_W-1:0]     r_range_a;
    logic [CFG_W-1:0]     r_range_b;
    logic [CFG_W-1:0]     r_range_c;
    t_box [NUM_BOXES-1:0] boxes;

    logic                 front_valid;
    t_item                front_item;
    logic                 div_valid [DIV_STAGES+1];
    t_item                div_item  [DIV_STAGES+1];
    logic                 arith_valid;
    t_hsv                 arith_hsv;
    t_hsv                 out_hsv;

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_a <= RANGE_A_RESET;
            r_range_b <= RANGE_B_RESET;
            r_range_c <= RANGE_C_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RANGE_A: r_range_a <= i_cfg_data;
                REG_RANGE_B: r_range_b <= i_cfg_data;
                REG_RANGE_C: r_range_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign boxes[0] = t_box'(r_range_a);
    assign boxes[1] = t_box'(r_range_b);
    assign boxes[2] = t_box'(r_range_c);

    hmrcm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_blue  (i_blue),
        .i_green (i_green),
        .i_red   (i_red),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    assign div_valid[0] = front_valid;
    assign div_item[0]  = front_item;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        hmrcm_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[g]),
            .i_item  (div_item[g]),
            .o_valid (div_valid[g+1]),
            .o_item  (div_item[g+1])
        );
    end

    hmrcm_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid[DIV_STAGES]),
        .i_item  (div_item[DIV_STAGES]),
        .o_valid (arith_valid),
        .o_hsv   (arith_hsv)
    );

    hmrcm_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (arith_valid),
        .i_hsv   (arith_hsv),
        .i_boxes (boxes),
        .o_valid (o_valid),
        .o_mask  (o_mask_bit),
        .o_hsv   (out_hsv)
    );

    assign o_hue        = out_hsv.hue;
    assign o_saturation = out_hsv.sat;
    assign o_brightness = out_hsv.val;

endmodule

### rtl/core/hmrcm_checker.sv
// ----------------------------------------------------------------------------
// hmrcm_assert
// Port-level checks of the HSV color mask, bound to the top level.
// ----------------------------------------------------------------------------
module hmrcm_assert import hmrcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic                 o_mask_bit,
    input  logic [PIX_W-1:0]     o_hue,
    input  logic [PIX_W-1:0]     o_saturation,
    input  logic [PIX_W-1:0]     o_brightness
);

    // A stalled result item holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mask_bit) && $stable(o_hue) &&
                               $stable(o_saturation) && $stable(o_brightness))
        else $error("result item changed while stalled");

    // The input side is only held back by a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with an empty output register");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue < 8'(HUE_WRAP))
        else $error("hue out of range");

    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == '0 |-> o_saturation == '0)
        else $error("black pixel with nonzero saturation");

    // Zero saturation only comes from a gray pixel, whose hue is zero.
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation == '0 |-> o_hue == '0)
        else $error("gray pixel with nonzero hue");

endmodule

bind hsv_multi_range_color_mask hmrcm_assert u_hmrcm_assert (.*);

### tb/hmrcm_checker.sv
// ----------------------------------------------------------------------------
// hmrcm_checker
// Watches the pixel and result channels of the HSV color mask and the
// configuration port. It computes the expected HSV values and mask bit of
// every accepted pixel and compares each accepted result, field by field,
// with the oldest pending expectation.
// ----------------------------------------------------------------------------
module hmrcm_checker import hmrcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_stall,
    input  logic [PIX_W-1:0]     i_blue,
    input  logic [PIX_W-1:0]     i_green,
    input  logic [PIX_W-1:0]     i_red,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic                 i_mask_bit,
    input  logic [PIX_W-1:0]     i_hue,
    input  logic [PIX_W-1:0]     i_saturation,
    input  logic [PIX_W-1:0]     i_brightness,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic hit;
        t_hsv hsv;
    } t_masked_pixel;

    t_box          boxes [NUM_BOXES];
    t_masked_pixel masked_pixels_due [$];
    int            results_seen = 0;

    function automatic t_hsv to_hsv(input logic [PIX_W-1:0] b, g, r);
        int     hi, lo, spread, raw;
        longint s_recip, h_recip, s_full, t;
        t_hsv   p;
        hi = b;
        lo = b;
        if (g > hi) hi = g;
        if (r > hi) hi = r;
        if (g < lo) lo = g;
        if (r < lo) lo = r;
        spread = hi - lo;

        // Both reciprocals carry 12 fraction bits and are rounded to nearest.
        s_recip = 0;
        h_recip = 0;
        if (hi > 0)
            s_recip = ((longint'(2 * 255) <<< FIX_SHIFT) + hi) / (2 * hi);
        if (spread > 0)
            h_recip = ((longint'(2 * 30) <<< FIX_SHIFT) + spread) / (2 * spread);

        s_full = (spread * s_recip + (longint'(1) <<< (FIX_SHIFT - 1))) >>> FIX_SHIFT;
        if (s_full > 255) s_full = 255;

        // Red wins a tie for the maximum, then green, then blue.
        if (hi == r)
            raw = int'(g) - int'(b);
        else if (hi == g)
            raw = int'(b) - int'(r) + 2 * spread;
        else
            raw = int'(r) - int'(g) + 4 * spread;

        // A bias of 180 whole units keeps the value positive before the shift.
        t = raw * h_recip + (longint'(1) <<< (FIX_SHIFT - 1))
            + (longint'(180) <<< FIX_SHIFT);
        if (t < 0) t = 0;
        t = t >>> FIX_SHIFT;
        if (t >= 180) t = t - 180;
        if (t > 255) t = 255;

        p.hue = PIX_W'(t);
        p.sat = PIX_W'(s_full);
        p.val = PIX_W'(hi);
        return p;
    endfunction

    // A box whose low bound exceeds its high bound in any channel holds nothing.
    function automatic logic box_holds(input t_box bx, input t_hsv p);
        return p.hue >= bx.lo_h && p.hue <= bx.hi_h &&
               p.sat >= bx.lo_s && p.sat <= bx.hi_s &&
               p.val >= bx.lo_v && p.val <= bx.hi_v;
    endfunction

    function automatic t_masked_pixel convert_and_mask(input logic [PIX_W-1:0] b, g, r);
        t_masked_pixel m;
        m.hsv = to_hsv(b, g, r);
        m.hit = 1'b0;
        for (int k = 0; k < NUM_BOXES; k++)
            if (box_holds(boxes[k], m.hsv)) m.hit = 1'b1;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: result %0d: %s is %0d, expected %0d",
                 $realtime, results_seen, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_masked_pixel want;
        if (!i_rst_n) begin
            boxes[0] = t_box'(RANGE_A_RESET);
            boxes[1] = t_box'(RANGE_B_RESET);
            boxes[2] = t_box'(RANGE_C_RESET);
            masked_pixels_due.delete();
            o_fail_count = 0;
            o_in_flight  = 0;
        end else begin
            // A pixel taken at this edge still sees the boxes from before it.
            if (i_pix_valid && !i_pix_stall)
                masked_pixels_due = {masked_pixels_due,
                                     convert_and_mask(i_blue, i_green, i_red)};

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANGE_A: boxes[0] = t_box'(i_cfg_data);
                    REG_RANGE_B: boxes[1] = t_box'(i_cfg_data);
                    REG_RANGE_C: boxes[2] = t_box'(i_cfg_data);
                    default: ;
                endcase
            end

            if (i_res_valid && !i_res_stall) begin
                if (masked_pixels_due.size() == 0) begin
                    report_mismatch("result with no pixel pending", i_hue, 0);
                end else begin
                    want = masked_pixels_due.pop_front();
                    if (i_mask_bit !== want.hit)
                        report_mismatch("mask_bit", i_mask_bit, want.hit);
                    if (i_hue !== want.hsv.hue)
                        report_mismatch("hue", i_hue, want.hsv.hue);
                    if (i_saturation !== want.hsv.sat)
                        report_mismatch("saturation", i_saturation, want.hsv.sat);
                    if (i_brightness !== want.hsv.val)
                        report_mismatch("brightness", i_brightness, want.hsv.val);
                end
                results_seen++;
            end
            o_in_flight = masked_pixels_due.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the HSV multi-range color mask. It sends directed pixels at
// the channel extremes and hue corner cases, then phases of random pixels,
// each phase under a new set of HSV boxes, with random gaps on the pixel side
// and random stalls on the result side. A checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb import hmrcm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int NUM_PHASES      = 8;
    localparam int PIXELS_PER_PHASE = 75;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 20;

    typedef enum int {
        BOX_RESET, BOX_ZERO, BOX_ONES, BOX_FULL, BOX_EMPTY, BOX_WINDOW, BOX_NOISE
    } t_box_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [PIX_W-1:0]     i_blue;
    logic [PIX_W-1:0]     i_green;
    logic [PIX_W-1:0]     i_red;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_mask_bit;
    logic [PIX_W-1:0]     o_hue;
    logic [PIX_W-1:0]     o_saturation;
    logic [PIX_W-1:0]     o_brightness;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    int fail_count;
    int in_flight;
    int idle_cycles = 0;
    bit pix_hurry = 1'b0;
    bit res_hurry = 1'b0;

    always #5 i_clk = ~i_clk;

    hsv_multi_range_color_mask i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mask_bit   (o_mask_bit),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    hmrcm_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_stall  (o_stall),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_mask_bit   (o_mask_bit),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .i_brightness (o_brightness),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_in_flight  (in_flight)
    );

    function automatic logic [CFG_W-1:0] make_box(input t_box_kind kind, input int slot);
        t_box        bx;
        int unsigned lo;
        logic [63:0] wide;
        bx = t_box'(48'h000000_FFFFFF);
        case (kind)
            BOX_RESET: begin
                if (slot == 0) bx = t_box'(RANGE_A_RESET);
                else if (slot == 1) bx = t_box'(RANGE_B_RESET);
                else bx = t_box'(RANGE_C_RESET);
            end
            BOX_ZERO: bx = '0;
            BOX_ONES: bx = '1;
            BOX_FULL: ;
            BOX_EMPTY: begin
                // Open in every channel but one, where low sits above high.
                lo = $urandom_range(1, 255);
                case ($urandom_range(0, 2))
                    0: begin
                        bx.lo_h = PIX_W'(lo);
                        bx.hi_h = PIX_W'($urandom_range(0, lo - 1));
                    end
                    1: begin
                        bx.lo_s = PIX_W'(lo);
                        bx.hi_s = PIX_W'($urandom_range(0, lo - 1));
                    end
                    default: begin
                        bx.lo_v = PIX_W'(lo);
                        bx.hi_v = PIX_W'($urandom_range(0, lo - 1));
                    end
                endcase
            end
            BOX_WINDOW: begin
                lo      = $urandom_range(0, 179);
                bx.lo_h = PIX_W'(lo);
                bx.hi_h = PIX_W'(lo + $urandom_range(0, 76));
                lo      = $urandom_range(0, 160);
                bx.lo_s = PIX_W'(lo);
                bx.hi_s = PIX_W'(lo + $urandom_range(0, 95));
                lo      = $urandom_range(0, 160);
                bx.lo_v = PIX_W'(lo);
                bx.hi_v = PIX_W'(lo + $urandom_range(0, 95));
            end
            default: begin
                wide = {$urandom(), $urandom()};
                bx   = t_box'(wide[CFG_W-1:0]);
            end
        endcase
        return bx;
    endfunction

    // Holds valid high across back-to-back items; lowers it only for a gap.
    task automatic send_pixel(input logic [PIX_W-1:0] b, g, r);
        int gap;
        gap = pix_hurry ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_blue  <= b;
        i_green <= g;
        i_red   <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    // The boxes are read live, so they change only once the pipeline is empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (in_flight != 0) @(posedge i_clk);
    endtask

    // Result side: a random stall before every item.
    initial begin : result_sink
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = res_hurry ? 0 : $urandom_range(0, 19);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [CFG_IDX_W-1:0] reg_order [4];
        t_box_kind            kind;
        logic [PIX_W-1:0]     b, g, r;

        reg_order[0] = REG_RANGE_A;
        reg_order[1] = REG_RANGE_B;
        reg_order[2] = REG_RANGE_C;
        reg_order[3] = REG_UNUSED;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_blue     <= '0;
        i_green    <= '0;
        i_red      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_RANGE_A;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels (blue, green, red) under the reset boxes.
        send_pixel(8'd0,   8'd0,   8'd0);     // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // mid gray
        send_pixel(8'd0,   8'd0,   8'd255);   // pure red
        send_pixel(8'd0,   8'd255, 8'd0);     // pure green
        send_pixel(8'd255, 8'd0,   8'd0);     // pure blue
        send_pixel(8'd255, 8'd0,   8'd255);   // red ties blue
        send_pixel(8'd0,   8'd255, 8'd255);   // red ties green
        send_pixel(8'd255, 8'd255, 8'd0);     // green ties blue
        send_pixel(8'd200, 8'd0,   8'd255);   // red max, negative hue wraps
        send_pixel(8'd1,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);     // smallest nonzero value
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd32,  8'd64,  8'd128);
        send_pixel(8'd100, 8'd200, 8'd30);
        send_pixel(8'd150, 8'd230, 8'd150);   // bright green, inside the third box
        send_pixel(8'd40,  8'd50,  8'd45);    // dark green, inside the first box
        send_pixel(8'h55,  8'hAA,  8'h55);
        send_pixel(8'hAA,  8'h55,  8'hAA);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            pix_hurry = ($urandom_range(0, 3) == 0);
            res_hurry = ($urandom_range(0, 3) == 0);

            // Three boxes plus one write to the unused index, which must be ignored.
            for (int slot = 0; slot < 4; slot++) begin
                if (slot == 3)
                    kind = BOX_NOISE;
                else if (phase == 1)
                    kind = BOX_FULL;
                else if (phase == 2)
                    kind = BOX_ZERO;
                else if (phase == 3)
                    kind = BOX_ONES;
                else if (phase == 4)
                    kind = BOX_EMPTY;
                else
                    kind = t_box_kind'($urandom_range(0, 6));
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= reg_order[slot];
                i_cfg_data <= make_box(kind, slot);
                @(posedge i_clk);
            end
            i_cfg_we <= 1'b0;

            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                b = PIX_W'($urandom());
                g = PIX_W'($urandom());
                r = PIX_W'($urandom());
                case ($urandom_range(0, 7))
                    0: begin
                        g = b;
                        r = b;
                    end
                    1: begin
                        case ($urandom_range(0, 2))
                            0: g = r;
                            1: b = r;
                            default: b = g;
                        endcase
                    end
                    2: begin
                        b = PIX_W'($urandom_range(0, 15));
                        g = PIX_W'($urandom_range(0, 15));
                        r = PIX_W'($urandom_range(0, 15));
                    end
                    3: begin
                        case ($urandom_range(0, 2))
                            0: begin b = '0; r = '1; end
                            1: begin g = '0; b = '1; end
                            default: begin r = '0; g = '1; end
                        endcase
                    end
                    default: ;
                endcase
                send_pixel(b, g, r);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && in_flight == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
